// File: rtl/pdtm_pkg.sv
// ----------------------------------------------------------------------------
// pdtm_pkg
// Shared types and constants for the programmable DFA / trie matcher.
// ----------------------------------------------------------------------------
package pdtm_pkg;

    // Allocation limit for pattern insertion (states are 8 bits wide)
    localparam int STATE_COUNT = 256;
    localparam int START_STATE = 0;
    localparam int NUM_IDS     = 256;
    localparam int CAPACITY    = (STATE_COUNT < NUM_IDS) ? STATE_COUNT : NUM_IDS;

    // Transition store geometry: one slot per (state, symbol)
    localparam int SLOT_AW    = 16;
    localparam int SLOT_COUNT = 1 << SLOT_AW;

    typedef logic [7:0]         state_id_t;
    typedef logic [7:0]         symbol_t;
    typedef logic [SLOT_AW-1:0] slot_addr_t;

    localparam state_id_t  START_ID     = state_id_t'(START_STATE);
    localparam logic [8:0] CAPACITY_W   = 9'(CAPACITY);
    localparam slot_addr_t SLOT_LAST    = slot_addr_t'(SLOT_COUNT - 1);

    // Command codes
    localparam logic [2:0] CMD_RESTART = 3'd0;
    localparam logic [2:0] CMD_STEP    = 3'd1;
    localparam logic [2:0] CMD_ADD     = 3'd2;
    localparam logic [2:0] CMD_MARK    = 3'd3;
    localparam logic [2:0] CMD_PATTERN = 3'd4;

    // One transition store entry
    typedef struct packed {
        logic      valid;
        state_id_t dest;
    } trans_entry_t;

    // Write request into the transition store
    typedef struct packed {
        logic         we;
        slot_addr_t   addr;
        trans_entry_t data;
    } trans_wr_t;

    // Result item, lowest field in the lowest bit
    typedef struct packed {
        logic      table_full;
        logic      match_result;
        logic      at_final;
        state_id_t state_now;
        logic      hit;
    } result_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } ctl_state_t;

endpackage

// File: rtl/pdtm_trans_store.sv
// ----------------------------------------------------------------------------
// pdtm_trans_store
// Transition store: 64K x 9 synchronous RAM with registered read data and a
// clearing sweep after reset that invalidates every slot.
// ----------------------------------------------------------------------------
module pdtm_trans_store (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_en,
    input  pdtm_pkg::slot_addr_t    rd_addr,
    input  pdtm_pkg::trans_wr_t     wr,
    output pdtm_pkg::trans_entry_t  rd_data,
    output logic                    clear_done
);
    import pdtm_pkg::*;

    trans_entry_t mem [SLOT_COUNT];
    trans_entry_t rd_data_reg;
    slot_addr_t   clr_addr_reg;
    logic         clr_busy_reg;

    // Clearing sweep, one slot per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + slot_addr_t'(1);
            if (clr_addr_reg == SLOT_LAST) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // RAM write port (sweep has priority) and registered read port
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_done = !clr_busy_reg;

endmodule

// File: rtl/programmable_dfa_trie_matcher_core.sv
// ----------------------------------------------------------------------------
// programmable_dfa_trie_matcher_core
// Table-driven byte automaton with trie-style pattern insertion.
// ----------------------------------------------------------------------------
// Sequence: transition RAM read in the accept cycle, update and write-back
//   with the final-mark RAM read, then the result cycle, after which m_tvalid
//   rises; a new item is accepted only after that. A held result stalls the
//   result cycle and the next accept with it.
// Reset: synchronous; control registers clear at once, then a sweep
//   invalidates the transition RAM (the 256 final marks clear in the same
//   window) with s_tready held low.
// ----------------------------------------------------------------------------
module programmable_dfa_trie_matcher_core (
    input  logic        aclk,
    input  logic        aresetn,
    // command[2:0], symbol[10:3], from_state[18:11], to_state[26:19], zero pad
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,   // last
    input  logic        s_tvalid,
    output logic        s_tready,
    // hit[0], state_now[8:1], at_final[9], match_result[10], table_full[11], pad
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import pdtm_pkg::*;

    ctl_state_t   state_reg, state_next;
    state_id_t    cur_state_reg, cur_state_next;
    state_id_t    highest_reg, highest_next;
    state_id_t    ins_cursor_reg, ins_cursor_next;
    logic         diverged_reg, diverged_next;
    logic         failed_reg, failed_next;

    // Latched item
    logic [2:0]   cmd_reg, cmd_next;
    symbol_t      sym_reg, sym_next;
    state_id_t    from_reg, from_next;
    state_id_t    to_reg, to_next;
    logic         last_reg, last_next;

    // Per-item flags carried into the result cycle
    logic         hit_reg, hit_next;
    logic         full_reg, full_next;
    logic         res_pend_reg, res_pend_next;
    logic         fin_fwd_reg, fin_fwd_next;

    // Output register
    logic         m_valid_reg, m_valid_next;
    result_t      m_data_reg, m_data_next;

    // Store interface
    logic         rd_en;
    slot_addr_t   rd_addr;
    trans_wr_t    wr;
    trans_entry_t entry;
    logic         clear_done;

    // Final-mark RAM
    logic         final_mem [NUM_IDS];
    logic         fin_rd_reg;
    logic [8:0]   fin_clr_reg;
    logic         fin_we;
    state_id_t    fin_waddr;
    logic         fin_wdata;
    logic         fin_re;
    state_id_t    fin_raddr;

    // Input field views
    logic [2:0]   in_cmd;
    symbol_t      in_sym;
    state_id_t    in_from;
    state_id_t    in_to;

    assign in_cmd  = s_tdata[2:0];
    assign in_sym  = s_tdata[10:3];
    assign in_from = s_tdata[18:11];
    assign in_to   = s_tdata[26:19];

    pdtm_trans_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .wr         (wr),
        .rd_data    (entry),
        .clear_done (clear_done)
    );

    // Final-mark clearing sweep, one entry per cycle after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_clr_reg <= '0;
        end else if (!fin_clr_reg[8]) begin
            fin_clr_reg <= fin_clr_reg + 9'd1;
        end
    end

    // Final-mark RAM: one write port, registered read port
    always_ff @(posedge aclk) begin
        if (fin_we) begin
            final_mem[fin_waddr] <= fin_wdata;
        end
        if (fin_re) begin
            fin_rd_reg <= final_mem[fin_raddr];
        end
    end

    // Control state and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            cur_state_reg  <= START_ID;
            highest_reg    <= '0;
            ins_cursor_reg <= START_ID;
            diverged_reg   <= 1'b0;
            failed_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_state_reg  <= cur_state_next;
            highest_reg    <= highest_next;
            ins_cursor_reg <= ins_cursor_next;
            diverged_reg   <= diverged_next;
            failed_reg     <= failed_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        sym_reg      <= sym_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        last_reg     <= last_next;
        hit_reg      <= hit_next;
        full_reg     <= full_next;
        res_pend_reg <= res_pend_next;
        fin_fwd_reg  <= fin_fwd_next;
        m_data_reg   <= m_data_next;
    end

    // Next state, datapath and handshakes
    always_comb begin
        logic       mark_we;
        state_id_t  mark_addr;
        logic [8:0] alloc_id;
        logic       final_bit;

        state_next      = state_reg;
        cur_state_next  = cur_state_reg;
        highest_next    = highest_reg;
        ins_cursor_next = ins_cursor_reg;
        diverged_next   = diverged_reg;
        failed_next     = failed_reg;
        cmd_next        = cmd_reg;
        sym_next        = sym_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        last_next       = last_reg;
        hit_next        = hit_reg;
        full_next       = full_reg;
        res_pend_next   = res_pend_reg;
        fin_fwd_next    = fin_fwd_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        s_tready        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = {cur_state_reg, in_sym};
        wr              = '0;
        fin_we          = !fin_clr_reg[8];
        fin_waddr       = fin_clr_reg[7:0];
        fin_wdata       = 1'b0;
        fin_re          = 1'b0;
        fin_raddr       = cur_state_reg;
        mark_we         = 1'b0;
        mark_addr       = from_reg;
        alloc_id        = {1'b0, highest_reg} + 9'd1;
        final_bit       = fin_rd_reg || fin_fwd_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                if (clear_done && fin_clr_reg[8]) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next   = in_cmd;
                    sym_next   = in_sym;
                    from_next  = in_from;
                    to_next    = in_to;
                    last_next  = s_tlast;
                    rd_en      = 1'b1;
                    if (in_cmd == CMD_PATTERN) begin
                        rd_addr = {ins_cursor_reg, in_sym};
                    end
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                hit_next      = 1'b0;
                full_next     = 1'b0;
                res_pend_next = 1'b0;
                unique case (cmd_reg)
                    CMD_RESTART: begin
                        cur_state_next = START_ID;
                        failed_next    = 1'b0;
                    end
                    CMD_STEP: begin
                        if (entry.valid) begin
                            cur_state_next = entry.dest;
                            hit_next       = 1'b1;
                        end else begin
                            failed_next = 1'b1;
                        end
                        res_pend_next = last_reg && !failed_next;
                    end
                    CMD_ADD: begin
                        wr.we   = 1'b1;
                        wr.addr = {from_reg, sym_reg};
                        wr.data = '{valid: 1'b1, dest: to_reg};
                        if (to_reg > highest_reg) begin
                            highest_next = to_reg;
                        end
                    end
                    CMD_MARK: begin
                        mark_we   = 1'b1;
                        mark_addr = from_reg;
                    end
                    CMD_PATTERN: begin
                        if (!diverged_reg && entry.valid) begin
                            // follow existing trie edge
                            ins_cursor_next = entry.dest;
                            if (last_reg) begin
                                mark_we         = 1'b1;
                                mark_addr       = entry.dest;
                                ins_cursor_next = START_ID;
                            end
                        end else if (alloc_id >= CAPACITY_W) begin
                            // out of states: flag only, restart on last
                            full_next = 1'b1;
                            if (last_reg) begin
                                ins_cursor_next = START_ID;
                                diverged_next   = 1'b0;
                            end
                        end else begin
                            // allocate a fresh state
                            wr.we           = 1'b1;
                            wr.addr         = {ins_cursor_reg, sym_reg};
                            wr.data         = '{valid: 1'b1, dest: alloc_id[7:0]};
                            highest_next    = alloc_id[7:0];
                            ins_cursor_next = alloc_id[7:0];
                            diverged_next   = 1'b1;
                            if (last_reg) begin
                                mark_we         = 1'b1;
                                mark_addr       = alloc_id[7:0];
                                ins_cursor_next = START_ID;
                                diverged_next   = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                // Mark write and read of the new state's mark, forwarded on a match
                if (mark_we) begin
                    fin_we    = 1'b1;
                    fin_waddr = mark_addr;
                    fin_wdata = 1'b1;
                end
                fin_re       = 1'b1;
                fin_raddr    = cur_state_next;
                fin_fwd_next = mark_we && (mark_addr == cur_state_next);
                state_next   = ST_REPORT;
            end

            ST_REPORT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.hit          = hit_reg;
                    m_data_next.state_now    = cur_state_reg;
                    m_data_next.at_final     = final_bit;
                    m_data_next.match_result = res_pend_reg && final_bit;
                    m_data_next.table_full   = full_reg;
                    state_next               = ST_IDLE;
                end
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_data_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during transition store clear");

    a_store_write_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.we |-> (state_reg == ST_EXEC))
        else $error("transition store written outside execute cycle");

    a_exec_yields_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPORT && state_next == ST_IDLE) |=> m_valid_reg)
        else $error("completed item produced no result");

    a_highest_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> highest_reg >= $past(highest_reg))
        else $error("highest state decreased");

    a_match_implies_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.match_result) |->
            (m_data_reg.at_final && m_data_reg.hit && !m_data_reg.table_full))
        else $error("match reported without final hit");

endmodule

// File: dv/programmable_dfa_trie_matcher_core_tb.sv
// ----------------------------------------------------------------------------
// programmable_dfa_trie_matcher_core_tb
// Self-checking bench for the table-driven automaton. Every transaction on the
// input stream runs through a predictor that keeps its own transition table,
// final marks, walk state and trie insertion cursor. The predicted result is
// queued, and each result transaction is checked field by field against the
// oldest entry. Directed tests cover the empty table, programmed walks,
// overwrites, trie insertion and unused commands. A long random phase follows
// with pattern inserts, dictionary walks, edits and noise. A final test pushes
// the highest state to the top to force insertion overflow.
// ----------------------------------------------------------------------------
module programmable_dfa_trie_matcher_core_tb;
    import pdtm_pkg::*;

    localparam int          RANDOM_ITEMS = 1000;
    localparam int          DRAIN_EVERY  = 250;
    localparam int          TAIL_CYCLES  = 8;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam longint      RUN_LIMIT    = 64'd12_000_000;
    localparam logic [2:0]  CMD_RSVD_LO  = 3'd5;
    localparam logic [2:0]  CMD_RSVD_HI  = 3'd7;

    // One dictionary word, as inserted into the trie
    typedef struct {
        int      len;
        symbol_t ch [8];
    } word_t;

    logic        aclk;
    logic        aresetn;
    logic [31:0] s_tdata;   // command[2:0], symbol[10:3], from_state[18:11], to_state[26:19]
    logic        s_tlast;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;   // hit[0], state_now[8:1], at_final[9], match_result[10], table_full[11]
    logic        m_tvalid;
    logic        m_tready;

    // Predictor state
    bit [8:0]  trans_mem [0:SLOT_COUNT-1];   // bit 8 = valid, [7:0] = destination
    bit        final_mark [0:NUM_IDS-1];
    state_id_t cur_state    = START_ID;
    state_id_t top_state    = '0;
    state_id_t ins_cursor   = START_ID;
    bit        ins_diverged = 1'b0;
    bit        miss_seen    = 1'b0;

    result_t   pending_results [$];
    word_t     words_q [$];
    result_t   want_res;
    result_t   got_res;
    int        err_cnt      = 0;
    int        tx_gap_max   = 8;
    int        rx_stall_max = 8;

    programmable_dfa_trie_matcher_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Advance the automaton model by one command and return the result
    function automatic result_t predict_item(logic [2:0] cmd, symbol_t sym, state_id_t from,
                                             state_id_t to, logic last);
        result_t  r;
        bit [8:0] ent;
        bit       mark_end;
        r = '0;
        mark_end = 1'b0;
        case (cmd)
            CMD_RESTART: begin
                cur_state = START_ID;
                miss_seen = 1'b0;
            end
            CMD_STEP: begin
                ent = trans_mem[{cur_state, sym}];
                if (ent[8]) begin
                    cur_state = ent[7:0];
                    r.hit = 1'b1;
                end else begin
                    miss_seen = 1'b1;
                end
                if (last)
                    r.match_result = !miss_seen && final_mark[cur_state];
            end
            CMD_ADD: begin
                trans_mem[{from, sym}] = {1'b1, to};
                if (to > top_state)
                    top_state = to;
            end
            CMD_MARK: begin
                final_mark[from] = 1'b1;
            end
            CMD_PATTERN: begin
                ent = trans_mem[{ins_cursor, sym}];
                if (!ins_diverged && ent[8]) begin
                    // shared prefix: follow the existing edge
                    ins_cursor = ent[7:0];
                    mark_end = last;
                end else if (int'(top_state) + 1 >= CAPACITY) begin
                    // no room for a new state; nothing changes but the cursor on last
                    r.table_full = 1'b1;
                    if (last) begin
                        ins_cursor = START_ID;
                        ins_diverged = 1'b0;
                    end
                end else begin
                    top_state = top_state + 8'd1;
                    trans_mem[{ins_cursor, sym}] = {1'b1, top_state};
                    ins_cursor = top_state;
                    ins_diverged = 1'b1;
                    mark_end = last;
                end
                if (mark_end) begin
                    final_mark[ins_cursor] = 1'b1;
                    ins_cursor = START_ID;
                    ins_diverged = 1'b0;
                end
            end
            default: ;
        endcase
        r.state_now = cur_state;
        r.at_final = final_mark[cur_state];
        return r;
    endfunction

    function automatic symbol_t pick_letter();
        case ($urandom_range(3, 0))
            0:       return 8'h00;
            1:       return 8'h61;
            2:       return 8'hA5;
            default: return 8'hFF;
        endcase
    endfunction

    // Send one input transaction, then queue its predicted result
    task automatic send_item(logic [2:0] cmd, symbol_t sym, state_id_t from, state_id_t to,
                             logic last);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(tx_gap_max, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {5'd0, to, from, sym, cmd};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_item(cmd, sym, from, to, last));
    endtask

    // Hold off the sender until every queued result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
            err_cnt++;
        end
    endtask

    // Result sink with random backpressure
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = (rx_stall_max > 0) ? $urandom_range(rx_stall_max, 0) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $time, m_tdata);
                err_cnt++;
            end else begin
                want_res = pending_results.pop_front();
                got_res = result_t'(m_tdata[11:0]);
                check_field("hit", want_res.hit, got_res.hit);
                check_field("state_now", want_res.state_now, got_res.state_now);
                check_field("at_final", want_res.at_final, got_res.at_final);
                check_field("match_result", want_res.match_result, got_res.match_result);
                check_field("table_full", want_res.table_full, got_res.table_full);
            end
        end
    end

    // Walks over an empty table: every step misses
    task automatic test_empty_store();
        send_item(CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_RESTART, 8'h00, 8'h00, 8'h00, 1'b0);
    endtask

    // Hand-programmed edges, final marks and an overwritten edge
    task automatic test_programmed_walk();
        send_item(CMD_ADD, 8'h61, START_ID, 8'd1, 1'b0);
        send_item(CMD_ADD, 8'hFF, 8'd1, 8'd2, 1'b0);
        send_item(CMD_ADD, 8'h00, 8'hFF, 8'd0, 1'b1);
        send_item(CMD_MARK, 8'h00, 8'd2, 8'h00, 1'b0);
        send_item(CMD_RESTART, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'h61, 8'h00, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'hFF, 8'h00, 8'h00, 1'b1);
        // overwrite the first edge; the old path now breaks
        send_item(CMD_ADD, 8'h61, START_ID, 8'd3, 1'b0);
        send_item(CMD_RESTART, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'h61, 8'h00, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'hFF, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RESTART, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(CMD_MARK, 8'h00, 8'd3, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'h61, 8'h00, 8'h00, 1'b1);
    endtask

    // Trie insertion: shared prefix, then fresh states after divergence
    task automatic test_pattern_insert();
        send_item(CMD_PATTERN, 8'h61, 8'h00, 8'h00, 1'b0);
        send_item(CMD_PATTERN, 8'h62, 8'h00, 8'h00, 1'b0);
        send_item(CMD_PATTERN, 8'h63, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PATTERN, 8'h00, 8'hFF, 8'hFF, 1'b1);
        send_item(CMD_RESTART, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'h61, 8'h00, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'h62, 8'h00, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'h63, 8'h00, 8'h00, 1'b1);
    endtask

    // Reserved command codes leave everything alone
    task automatic test_unused_commands();
        for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
            send_item(3'(c), 8'hFF, 8'hFF, 8'hFF, 1'($urandom));
    endtask

    // Random mix of insertions, dictionary walks, edits and noise
    task automatic test_random_traffic();
        int    n;
        int    next_drain;
        int    pick;
        int    len;
        bit    ended;
        word_t w;
        n = 0;
        next_drain = DRAIN_EVERY;
        while (n < RANDOM_ITEMS) begin
            // rotate idling modes every hundred transactions
            case ((n / 100) % 4)
                0:       begin tx_gap_max = 8; rx_stall_max = 8; end
                1:       begin tx_gap_max = 0; rx_stall_max = 8; end
                2:       begin tx_gap_max = 8; rx_stall_max = 0; end
                default: begin tx_gap_max = 0; rx_stall_max = 0; end
            endcase
            if (n >= next_drain) begin
                wait_for_results();
                next_drain += DRAIN_EVERY;
            end
            pick = $urandom_range(99, 0);
            if (pick < 30) begin
                // insert a pattern; now and then cut it short without last
                len = $urandom_range(5, 1);
                ended = ($urandom_range(7, 0) != 0);
                w.len = len;
                for (int i = 0; i < len; i++) begin
                    w.ch[i] = pick_letter();
                    send_item(CMD_PATTERN, w.ch[i], 8'($urandom), 8'($urandom),
                              ended && (i == len - 1));
                end
                if (ended)
                    words_q.push_back(w);
                n += len;
            end else if (pick < 65) begin
                // walk a known word, sometimes with a corrupted letter
                if (words_q.size() == 0) begin
                    w.len = $urandom_range(4, 1);
                    for (int i = 0; i < w.len; i++)
                        w.ch[i] = pick_letter();
                end else begin
                    w = words_q[$urandom_range(words_q.size() - 1, 0)];
                end
                if ($urandom_range(5, 0) == 0)
                    w.ch[$urandom_range(w.len - 1, 0)] = 8'($urandom);
                if ($urandom_range(7, 0) != 0) begin
                    send_item(CMD_RESTART, 8'($urandom), 8'($urandom), 8'($urandom),
                              1'($urandom));
                    n++;
                end
                for (int i = 0; i < w.len; i++)
                    send_item(CMD_STEP, w.ch[i], 8'($urandom), 8'($urandom),
                              i == w.len - 1);
                n += w.len;
            end else if (pick < 80) begin
                // add an edge, mostly inside the used state range
                send_item(CMD_ADD, 8'($urandom),
                          ($urandom_range(3, 0) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(int'(top_state), 0)),
                          ($urandom_range(9, 0) == 0 && top_state < 8'd250)
                              ? top_state + 8'd1 : 8'($urandom_range(int'(top_state), 0)),
                          1'($urandom));
                n++;
            end else if (pick < 88) begin
                send_item(CMD_MARK, 8'($urandom),
                          ($urandom_range(3, 0) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(int'(top_state), 0)),
                          8'($urandom), 1'($urandom));
                n++;
            end else begin
                send_item(3'($urandom_range(CMD_RSVD_HI, CMD_RESTART)), 8'($urandom),
                          8'($urandom), 8'($urandom), 1'($urandom));
                n++;
            end
        end
        tx_gap_max = 8;
        rx_stall_max = 8;
    endtask

    // Push the highest state to the top, then insertion must overflow
    task automatic test_capacity_overflow();
        send_item(CMD_ADD, 8'h7E, START_ID, 8'hFF, 1'b0);
        send_item(CMD_RESTART, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(CMD_MARK, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_item(CMD_STEP, 8'h7E, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PATTERN, 8'h3C, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PATTERN, 8'h7E, 8'h00, 8'h00, 1'b0);
        send_item(CMD_PATTERN, 8'h3C, 8'h00, 8'h00, 1'b0);
        send_item(CMD_PATTERN, 8'h3C, 8'h00, 8'h00, 1'b1);
        send_item(CMD_PATTERN, 8'h11, 8'h00, 8'h00, 1'b1);
    endtask

    // Test sequence
    initial begin
        aresetn  <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_store();
        test_programmed_walk();
        wait_for_results();
        test_pattern_insert();
        test_unused_commands();
        wait_for_results();
        test_random_traffic();
        wait_for_results();
        test_capacity_overflow();

        // drain, then watch for stray results
        s_tvalid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++)
            @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            err_cnt++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/pdtm_pkg.sv
rtl/pdtm_trans_store.sv
rtl/programmable_dfa_trie_matcher_core.sv
dv/programmable_dfa_trie_matcher_core_tb.sv
